>>> design/ipcm_pkg.sv
// Package for the IP exact-address and CIDR network match table.
// Holds table sizes, action and status codes, controller types and the prefix mask.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package ipcm_pkg;

    localparam int EXACT_DEPTH = 64;
    localparam int NET_DEPTH   = 64;
    localparam int EX_AW       = $clog2(EXACT_DEPTH);
    localparam int NET_AW      = $clog2(NET_DEPTH);
    localparam int EX_CW       = $clog2(EXACT_DEPTH + 1);
    localparam int NET_CW      = $clog2(NET_DEPTH + 1);
    localparam int SCAN_W      = (EX_CW > NET_CW) ? EX_CW : NET_CW;
    localparam logic [7:0] V4_MAX_BITS = 8'd32;
    localparam logic [7:0] V6_MAX_BITS = 8'd128;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_EXACT = 2'd1,
        ACT_NET   = 2'd2,
        ACT_MATCH = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_PREFIX = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_sts_t;

    function automatic logic [127:0] prefix_mask(input logic [7:0] plen);
        logic [127:0] m;
        m = ~({128{1'b1}} >> plen);
        return m;
    endfunction

endpackage

`default_nettype wire

>>> design/ipcm_ctrl.sv
// Controller state machine for the match table: accept, scan, finish.
// Depends on ipcm_pkg; drives the datapath through dp_cmd_t and reads dp_sts_t.
`default_nettype none

module ipcm_ctrl
    import ipcm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  dp_sts_t   sts,
    output dp_cmd_t   cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            S_FINISH:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/ipcm_datapath.sv
// Datapath of the match table: item registers, both table memories, scan and result.
// Depends on ipcm_pkg; commanded by ipcm_ctrl.
`default_nettype none

module ipcm_datapath
    import ipcm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  dp_cmd_t          cmd,
    output dp_sts_t          sts,
    input  wire logic [1:0]  action,
    input  wire logic        family,
    input  wire logic [63:0] addr_hi,
    input  wire logic [63:0] addr_lo,
    input  wire logic [7:0]  prefix_len,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             accepted,
    output logic             hit,
    output logic [1:0]       status,
    output logic [6:0]       exact_entries,
    output logic [6:0]       network_count,
    output logic [7:0]       entry_total
);

    logic [128:0] ex_mem  [EXACT_DEPTH];
    logic [136:0] net_mem [NET_DEPTH];

    action_t      act_reg;
    logic         fam_reg;
    logic [127:0] addr_reg;
    logic [127:0] netkey_reg;
    logic [7:0]   plen_reg;
    logic         bad_reg;
    logic         skip_reg;

    logic [EX_CW-1:0]  ex_used_reg;
    logic [NET_CW-1:0] net_used_reg;
    logic [SCAN_W-1:0] idx_reg;
    logic              pend_reg;
    logic              ex_ok_reg;
    logic              net_ok_reg;
    logic [128:0]      ex_rd_reg;
    logic [136:0]      net_rd_reg;
    logic              ex_found_reg;
    logic              net_found_reg;

    logic         out_valid_reg;
    logic         accepted_reg;
    logic         hit_reg;
    status_t      status_reg;

    logic [127:0] in_addr;
    logic [127:0] st_mask;
    logic         ex_in_range;
    logic         net_in_range;
    logic         ex_eq;
    logic         net_eq;
    logic         net_has;
    logic         ex_write;
    logic         net_write;
    logic         ex_full;
    logic         net_full;

    assign in_addr = family ? {addr_hi, addr_lo} : {addr_hi[63:32], 96'd0};
    assign ex_in_range  = idx_reg < SCAN_W'(ex_used_reg);
    assign net_in_range = idx_reg < SCAN_W'(net_used_reg);
    assign st_mask = prefix_mask(net_rd_reg[7:0]);
    assign ex_eq   = ex_ok_reg && (ex_rd_reg == {fam_reg, addr_reg});
    assign net_eq  = net_ok_reg && (net_rd_reg == {fam_reg, netkey_reg, plen_reg});
    assign net_has = net_ok_reg && (net_rd_reg[136] == fam_reg)
                     && ((net_rd_reg[135:8] & st_mask) == (addr_reg & st_mask));
    assign ex_full  = ex_used_reg >= EX_CW'(EXACT_DEPTH);
    assign net_full = net_used_reg >= NET_CW'(NET_DEPTH);
    assign ex_write  = cmd.finish && (act_reg == ACT_EXACT) && !ex_found_reg && !ex_full;
    assign net_write = cmd.finish && (act_reg == ACT_NET) && !bad_reg
                       && !net_found_reg && !net_full;

    always_comb
    begin
        sts.scan_done = !pend_reg && (skip_reg || (!ex_in_range && !net_in_range));
        sts.out_free  = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg    <= action_t'(action);
            fam_reg    <= family;
            addr_reg   <= in_addr;
            netkey_reg <= in_addr & prefix_mask(prefix_len);
            plen_reg   <= prefix_len;
            bad_reg    <= (action_t'(action) == ACT_NET)
                          && (prefix_len > (family ? V6_MAX_BITS : V4_MAX_BITS));
            skip_reg   <= (action_t'(action) == ACT_CLEAR)
                          || ((action_t'(action) == ACT_NET)
                          && (prefix_len > (family ? V6_MAX_BITS : V4_MAX_BITS)));
        end
        ex_rd_reg  <= ex_mem[idx_reg[EX_AW-1:0]];
        net_rd_reg <= net_mem[idx_reg[NET_AW-1:0]];
        if (ex_write)
        begin
            ex_mem[ex_used_reg[EX_AW-1:0]] <= {fam_reg, addr_reg};
        end
        if (net_write)
        begin
            net_mem[net_used_reg[NET_AW-1:0]] <= {fam_reg, netkey_reg, plen_reg};
        end
        if (cmd.finish)
        begin
            accepted_reg <= 1'b0;
            hit_reg      <= 1'b0;
            status_reg   <= ST_OK;
            case (act_reg)
                ACT_CLEAR:
                begin
                    accepted_reg <= 1'b1;
                end
                ACT_EXACT:
                begin
                    if (ex_found_reg || !ex_full)
                    begin
                        accepted_reg <= 1'b1;
                    end
                    else
                    begin
                        status_reg <= ST_FULL;
                    end
                end
                ACT_NET:
                begin
                    if (bad_reg)
                    begin
                        status_reg <= ST_PREFIX;
                    end
                    else if (net_found_reg || !net_full)
                    begin
                        accepted_reg <= 1'b1;
                    end
                    else
                    begin
                        status_reg <= ST_FULL;
                    end
                end
                ACT_MATCH:
                begin
                    hit_reg <= ex_found_reg || net_found_reg;
                end
                default:
                begin
                    hit_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_used_reg   <= '0;
            net_used_reg  <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            ex_ok_reg     <= 1'b0;
            net_ok_reg    <= 1'b0;
            ex_found_reg  <= 1'b0;
            net_found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg       <= '0;
                pend_reg      <= 1'b0;
                ex_ok_reg     <= 1'b0;
                net_ok_reg    <= 1'b0;
                ex_found_reg  <= 1'b0;
                net_found_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                if (ex_eq)
                begin
                    ex_found_reg <= 1'b1;
                end
                if ((act_reg == ACT_MATCH) ? net_has : net_eq)
                begin
                    net_found_reg <= 1'b1;
                end
                if (!skip_reg && (ex_in_range || net_in_range))
                begin
                    pend_reg   <= 1'b1;
                    ex_ok_reg  <= ex_in_range;
                    net_ok_reg <= net_in_range;
                    idx_reg    <= idx_reg + 1'b1;
                end
                else
                begin
                    pend_reg   <= 1'b0;
                    ex_ok_reg  <= 1'b0;
                    net_ok_reg <= 1'b0;
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (act_reg == ACT_CLEAR)
                begin
                    ex_used_reg  <= '0;
                    net_used_reg <= '0;
                end
                if (ex_write)
                begin
                    ex_used_reg <= ex_used_reg + 1'b1;
                end
                if (net_write)
                begin
                    net_used_reg <= net_used_reg + 1'b1;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    logic [EX_CW-1:0]  ex_cnt_reg;
    logic [NET_CW-1:0] net_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (act_reg == ACT_CLEAR)
            begin
                ex_cnt_reg  <= '0;
                net_cnt_reg <= '0;
            end
            else
            begin
                ex_cnt_reg  <= ex_used_reg + EX_CW'(ex_write);
                net_cnt_reg <= net_used_reg + NET_CW'(net_write);
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = accepted_reg;
    assign hit           = hit_reg;
    assign status        = status_reg;
    assign exact_entries = 7'(ex_cnt_reg);
    assign network_count = 7'(net_cnt_reg);
    assign entry_total   = 8'(ex_cnt_reg) + 8'(net_cnt_reg);

endmodule

`default_nettype wire

>>> design/ip_exact_and_cidr_match_table_core.sv
// Top level of the IP exact-address and CIDR network match table.
// Depends on ipcm_pkg, ipcm_ctrl and ipcm_datapath.
//
//   Channel  Direction  Handshake            Fields
//   input    in         in_valid / in_stall  action family addr_hi addr_lo prefix_len
//   result   out        out_valid/out_stall  accepted hit status exact_entries
//                                            network_count entry_total
//
// An add or a match scans both memories side by side, up to the larger of the exact
// entry and network counts, before its result is registered; the block takes no new
// input transaction until that result is registered. A clear or an over-long prefix
// skips the scan, and empty tables end it at once. Reset empties both tables at once.
// A result waits in the output register while out_stall is high; the next input
// transaction is taken meanwhile and holds in its last step until the slot frees.
`default_nettype none

module ip_exact_and_cidr_match_table_core
    import ipcm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic        family,
    input  wire logic [63:0] addr_hi,
    input  wire logic [63:0] addr_lo,
    input  wire logic [7:0]  prefix_len,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             accepted,
    output logic             hit,
    output logic [1:0]       status,
    output logic [6:0]       exact_entries,
    output logic [6:0]       network_count,
    output logic [7:0]       entry_total
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    ipcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ipcm_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .action        (action),
        .family        (family),
        .addr_hi       (addr_hi),
        .addr_lo       (addr_lo),
        .prefix_len    (prefix_len),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .accepted      (accepted),
        .hit           (hit),
        .status        (status),
        .exact_entries (exact_entries),
        .network_count (network_count),
        .entry_total   (entry_total)
    );

    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (exact_entries <= 7'(EXACT_DEPTH)) && (network_count <= 7'(NET_DEPTH)))
        else $error("entry count beyond table depth");

    a_total_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_total == 8'(exact_entries) + 8'(network_count)))
        else $error("entry total differs from sum of counts");

    a_reject_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (!accepted && !hit))
        else $error("rejected transaction reported as accepted");

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for ip_exact_and_cidr_match_table_core.
// Drives random add, clear and match transactions, predicts each result with a
// table model in the scoreboard class, and compares every result field.
// Depends on ipcm_pkg and the design files.
`timescale 1ns / 1ps

module tb;
    import ipcm_pkg::*;

    class match_table_scoreboard;
        logic [63:0] ex_hi[$];
        logic [63:0] ex_lo[$];
        logic        ex_fam[$];
        logic [63:0] nt_hi[$];
        logic [63:0] nt_lo[$];
        logic        nt_fam[$];
        logic [7:0]  nt_plen[$];
        logic [25:0] pending[$];
        int          errors;

        function void note_input(logic [1:0] act, logic fam, logic [63:0] hi,
                                 logic [63:0] lo, logic [7:0] plen);
            logic         acc;
            logic         hit_f;
            logic [1:0]   st;
            logic         found;
            logic [127:0] m;
            logic [127:0] a;
            acc = 1'b0;
            hit_f = 1'b0;
            st = ST_OK;
            found = 1'b0;
            if (!fam)
            begin
                hi[31:0] = 32'd0;
                lo = 64'd0;
            end
            a = {hi, lo};
            case (act)
                ACT_CLEAR:
                begin
                    ex_hi.delete(); ex_lo.delete(); ex_fam.delete();
                    nt_hi.delete(); nt_lo.delete(); nt_fam.delete(); nt_plen.delete();
                    acc = 1'b1;
                end
                ACT_EXACT:
                begin
                    foreach (ex_hi[i])
                        if (ex_fam[i] == fam && ex_hi[i] == hi && ex_lo[i] == lo)
                            found = 1'b1;
                    if (found)
                        acc = 1'b1;
                    else if (ex_hi.size() >= EXACT_DEPTH)
                        st = ST_FULL;
                    else
                    begin
                        ex_hi.push_back(hi); ex_lo.push_back(lo); ex_fam.push_back(fam);
                        acc = 1'b1;
                    end
                end
                ACT_NET:
                begin
                    if (plen > (fam ? 8'd128 : 8'd32))
                        st = ST_PREFIX;
                    else
                    begin
                        m = (plen == 0) ? 128'd0 : ~(128'd0) << (128 - plen);
                        a = a & m;
                        foreach (nt_hi[i])
                            if (nt_fam[i] == fam && nt_plen[i] == plen &&
                                {nt_hi[i], nt_lo[i]} == a)
                                found = 1'b1;
                        if (found)
                            acc = 1'b1;
                        else if (nt_hi.size() >= NET_DEPTH)
                            st = ST_FULL;
                        else
                        begin
                            nt_hi.push_back(a[127:64]); nt_lo.push_back(a[63:0]);
                            nt_fam.push_back(fam); nt_plen.push_back(plen);
                            acc = 1'b1;
                        end
                    end
                end
                default:
                begin
                    foreach (ex_hi[i])
                        if (ex_fam[i] == fam && ex_hi[i] == hi && ex_lo[i] == lo)
                            hit_f = 1'b1;
                    foreach (nt_hi[i])
                    begin
                        m = (nt_plen[i] == 0) ? 128'd0 : ~(128'd0) << (128 - nt_plen[i]);
                        if (nt_fam[i] == fam && ({nt_hi[i], nt_lo[i]} & m) == (a & m))
                            hit_f = 1'b1;
                    end
                end
            endcase
            pending.push_back({acc, hit_f, st, 7'(ex_hi.size()), 7'(nt_hi.size()),
                               8'(ex_hi.size() + nt_hi.size())});
        endfunction

        function void check_result(logic acc, logic h, logic [1:0] st, logic [6:0] ec,
                                   logic [6:0] nc, logic [7:0] tot);
            logic [25:0] e;
            if (pending.size() == 0)
            begin
                $error("result with no transaction outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (acc !== e[25])
            begin
                $error("accepted expected %0d actual %0d", e[25], acc); errors++;
            end
            if (h !== e[24])
            begin
                $error("hit expected %0d actual %0d", e[24], h); errors++;
            end
            if (st !== e[23:22])
            begin
                $error("status expected %0d actual %0d", e[23:22], st); errors++;
            end
            if (ec !== e[21:15])
            begin
                $error("exact_entries expected %0d actual %0d", e[21:15], ec); errors++;
            end
            if (nc !== e[14:8])
            begin
                $error("network_count expected %0d actual %0d", e[14:8], nc); errors++;
            end
            if (tot !== e[7:0])
            begin
                $error("entry_total expected %0d actual %0d", e[7:0], tot); errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  action = ACT_CLEAR;
    logic        family = 1'b0;
    logic [63:0] addr_hi = 64'd0;
    logic [63:0] addr_lo = 64'd0;
    logic [7:0]  prefix_len = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        accepted;
    logic        hit;
    logic [1:0]  status;
    logic [6:0]  exact_entries;
    logic [6:0]  network_count;
    logic [7:0]  entry_total;

    match_table_scoreboard table_sb;
    bit          quiet_phase = 1'b0;
    int          idle_cycles = 0;
    logic [63:0] pool_hi[16];
    logic [63:0] pool_lo[16];

    ip_exact_and_cidr_match_table_core uut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            table_sb.note_input(action, family, addr_hi, addr_lo, prefix_len);
        if (rst_n && out_valid && !out_stall)
            table_sb.check_result(accepted, hit, status, exact_entries, network_count,
                                  entry_total);
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("ip_exact_and_cidr_match_table_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 6);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    task automatic send(logic [1:0] act, logic fam, logic [63:0] hi, logic [63:0] lo,
                        logic [7:0] plen);
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        family <= fam;
        addr_hi <= hi;
        addr_lo <= lo;
        prefix_len <= plen;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_random();
        logic [1:0]  act;
        logic        fam;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [7:0]  plen;
        int          k;
        act = $urandom_range(0, 60) == 0 ? ACT_CLEAR : action_t'($urandom_range(1, 3));
        fam = $urandom_range(0, 1);
        k = $urandom_range(0, 15);
        hi = pool_hi[k];
        lo = pool_lo[k];
        if ($urandom_range(0, 3) == 0)
        begin
            hi = {$urandom, $urandom};
            lo = {$urandom, $urandom};
        end
        else if ($urandom_range(0, 2) == 0)
            hi[$urandom_range(0, 63)] ^= 1'b1;
        plen = $urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, fam ? 128 : 32));
        send(act, fam, hi, lo, plen);
    endtask

    initial
    begin
        table_sb = new();
        foreach (pool_hi[i])
        begin
            pool_hi[i] = {$urandom, $urandom};
            pool_lo[i] = {$urandom, $urandom};
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(ACT_MATCH, 1'b0, 64'd0, 64'd0, 8'd0);
        send(ACT_EXACT, 1'b0, 64'hC0A8_0001_DEAD_BEEF, 64'hFFFF, 8'd0);
        send(ACT_EXACT, 1'b0, 64'hC0A8_0001_0000_0000, 64'd0, 8'd0);
        send(ACT_MATCH, 1'b0, 64'hC0A8_0001_1234_5678, 64'd1, 8'd0);
        send(ACT_EXACT, 1'b1, '1, '1, 8'd0);
        send(ACT_MATCH, 1'b1, '1, '1, 8'd0);
        send(ACT_NET, 1'b0, 64'h0A00_0000_0000_0000, 64'd0, 8'd33);
        send(ACT_NET, 1'b1, 64'd0, 64'd0, 8'd129);
        send(ACT_NET, 1'b1, 64'd0, 64'd0, 8'd255);
        send(ACT_NET, 1'b0, 64'h0A01_0203_FFFF_FFFF, 64'd5, 8'd8);
        send(ACT_NET, 1'b0, 64'h0A99_0000_0000_0000, 64'd0, 8'd8);
        send(ACT_MATCH, 1'b0, 64'h0AFF_FFFF_0000_0000, 64'd0, 8'd0);
        send(ACT_NET, 1'b1, '1, '1, 8'd128);
        send(ACT_NET, 1'b1, 64'h2001_0DB8_0000_0000, '1, 8'd64);
        send(ACT_NET, 1'b1, 64'h2001_0DB8_0000_0000, '1, 8'd65);
        send(ACT_MATCH, 1'b1, 64'h2001_0DB8_0000_0000, 64'h1234, 8'd0);
        send(ACT_NET, 1'b0, '1, '1, 8'd0);
        send(ACT_MATCH, 1'b0, 64'd0, 64'd0, 8'd0);
        send(ACT_CLEAR, 1'b1, '1, '1, 8'hFF);
        for (int i = 0; i < 66; i++)
            send(ACT_EXACT, 1'b1, 64'(i), '1, 8'd0);
        send(ACT_EXACT, 1'b1, 64'd3, '1, 8'd0);
        for (int i = 0; i < 66; i++)
            send(ACT_NET, 1'b1, 64'(i) << 40, 64'd0, 8'd24);
        send(ACT_NET, 1'b1, 64'd5 << 40, 64'd7, 8'd24);
        send(ACT_MATCH, 1'b1, 64'd63, '1, 8'd0);
        send(ACT_MATCH, 1'b1, 64'd70 << 40, 64'd0, 8'd0);
        send(ACT_CLEAR, 1'b0, 64'd0, 64'd0, 8'd0);

        for (int i = 0; i < 744; i++)
        begin
            if (i == 650)
                quiet_phase = 1'b1;
            send_random();
        end
        in_valid <= 1'b0;
        while (table_sb.pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (table_sb.errors == 0)
            $display("ip_exact_and_cidr_match_table_core: match");
        else
            $display("ip_exact_and_cidr_match_table_core: mismatch");
        $finish;
    end
endmodule
